// ===== rtl/spring_damper_multistep_integrator_unit_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the spring-damper integrator
// concurrent checks on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef SPRING_DAMPER_MULTISTEP_INTEGRATOR_UNIT_MACROS_SVH
`define SPRING_DAMPER_MULTISTEP_INTEGRATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SDMI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SDMI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SDMI_ASSERT_IMP(lbl, ante, cons, msg)
`define SDMI_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/sdmi_pkg.sv =====
// ---------------------------------------------------------------------------
// sdmi_pkg
// shared types, constants and helpers of the spring-damper integrator
// ---------------------------------------------------------------------------
package sdmi_pkg;

  localparam int DATA_W     = 32;
  localparam int REG_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int ACC_W      = 64;
  localparam int WEIGHT_W   = 6;
  localparam int HIST_SLOTS = 3;
  localparam int DOF_W      = 2;
  localparam int ORDER_W    = 2;

  // divide-by-three unit: 40 bit numerator, 8 bits per cycle
  localparam int DIV_W     = 40;
  localparam int DIV_BITS  = 8;
  localparam int DIV_CYC   = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = 3;
  localparam logic [2:0] DIVISOR = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP    = 3'd0,
    REG_INVERSE_MASS = 3'd1,
    REG_STIFFNESS    = 3'd2,
    REG_DAMPING      = 3'd3,
    REG_MAX_ORDER    = 3'd4,
    REG_DOF_COUNT    = 3'd5
  } cfg_reg_e;

  localparam logic [REG_W-1:0]   TIME_STEP_RST    = 31'd655;
  localparam logic [REG_W-1:0]   INVERSE_MASS_RST = 31'd65536;
  localparam logic [ORDER_W-1:0] MAX_ORDER_RST    = 2'd1;
  localparam logic [DOF_W-1:0]   DOF_COUNT_RST    = 2'd3;

  // multistep weights in twelfths, row = order - 1, column = history slot
  localparam logic signed [WEIGHT_W-1:0] AB_W12 [HIST_SLOTS][HIST_SLOTS] = '{
    '{6'sd12,  6'sd0,   6'sd0},
    '{6'sd18, -6'sd6,   6'sd0},
    '{6'sd23, -6'sd16,  6'sd5}
  };
  localparam logic signed [WEIGHT_W-1:0] AM_W12 [HIST_SLOTS][HIST_SLOTS] = '{
    '{6'sd12,  6'sd0,   6'sd0},
    '{6'sd6,   6'sd6,   6'sd0},
    '{6'sd5,   6'sd8,  -6'sd1}
  };

  localparam logic signed [ACC_W-1:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic sat_t sat32(input logic signed [ACC_W-1:0] x);
    sat_t r;
    r.clip = 1'b0;
    r.val  = x[DATA_W-1:0];
    if (x > S32_MAX) begin
      r.clip = 1'b1;
      r.val  = S32_MAX[DATA_W-1:0];
    end else if (x < S32_MIN) begin
      r.clip = 1'b1;
      r.val  = S32_MIN[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sdmi_if.sv =====
// ---------------------------------------------------------------------------
// sdmi_req_if / sdmi_rsp_if
// valid/ready channels carrying forces in and displacements out
// ---------------------------------------------------------------------------
interface sdmi_req_if import sdmi_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] force_a;
  logic signed [DATA_W-1:0] force_b;
  logic signed [DATA_W-1:0] force_c;

  modport source (output valid, output force_a, output force_b, output force_c,
                  input ready);
  modport sink   (input valid, input force_a, input force_b, input force_c,
                  output ready);
endinterface

interface sdmi_rsp_if import sdmi_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] displacement_a;
  logic signed [DATA_W-1:0] displacement_b;
  logic signed [DATA_W-1:0] displacement_c;
  logic                     saturated;

  modport source (output valid, output displacement_a, output displacement_b,
                  output displacement_c, output saturated, input ready);
  modport sink   (input valid, input displacement_a, input displacement_b,
                  input displacement_c, input saturated, output ready);
endinterface

// ===== rtl/spring_damper_multistep_integrator_unit.sv =====
// a new force transfer is taken only in idle, once the previous result is in the output register
// the pace is set by the single shared multiplier and the divide-by-three unit
//   (one division per weighted sum, one multiply per history term)
// reset: asynchronous active low, registers to their reset values, histories and
//   position cleared, step count zero, no result pending
// ---------------------------------------------------------------------------
// spring_damper_multistep_integrator_unit
// mass-spring-damper body advanced by adams-bashforth / adams-moulton steps
// ---------------------------------------------------------------------------
`include "spring_damper_multistep_integrator_unit_macros.svh"

module spring_damper_multistep_integrator_unit import sdmi_pkg::*; #(
  parameter int MAX_DOF       = 3,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sdmi_req_if.sink             req_i,
  sdmi_rsp_if.source           rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i
);

  // dof index width, at least one bit
  localparam int DIW = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;
  localparam logic [DOF_W-1:0] MAX_DOF_C = DOF_W'(MAX_DOF);
  localparam int NUM_OUT = 3;

  typedef enum logic [3:0] {
    ST_IDLE,      // waiting for a force transfer
    ST_KX,        // issue stiffness * displacement
    ST_CV,        // subtract spring term, issue damping * velocity
    ST_FSUM,      // net force, shift force history
    ST_MAC_MUL,   // issue weight * history slot
    ST_MAC_ACC,   // accumulate the product
    ST_DIV_INIT,  // start the twelfths division
    ST_DIV_WAIT,
    ST_DIV_END,   // signed, saturated quotient
    ST_T_MUL,     // issue w * time step
    ST_T_RND,
    ST_IM_MUL,    // issue t * inverse mass
    ST_U_RND,
    ST_V_UPD,     // new velocity, shift velocity history
    ST_X_UPD,     // new displacement, move to next dof
    ST_DONE       // hand result to the output register
  } state_e;

  typedef enum logic {
    PH_AB,
    PH_AM
  } phase_e;

  // configuration
  logic [REG_W-1:0]   ts_q;
  logic [REG_W-1:0]   im_q;
  logic [REG_W-1:0]   k_q;
  logic [REG_W-1:0]   c_q;
  logic [ORDER_W-1:0] mo_q;
  logic [DOF_W-1:0]   dc_q;

  // integrator state
  logic signed [DATA_W-1:0] pos_q [MAX_DOF];
  logic signed [DATA_W-1:0] vh_q  [HIST_SLOTS][MAX_DOF];
  logic signed [DATA_W-1:0] fh_q  [HIST_SLOTS][MAX_DOF];
  logic [1:0]               steps_q;

  // sequencer and working registers
  state_e                   state_q;
  phase_e                   phase_q;
  logic [DOF_W-1:0]         dof_q;
  logic [DOF_W-1:0]         active_q;
  logic [ORDER_W-1:0]       order_q;
  logic [1:0]               j_q;
  logic signed [DATA_W-1:0] force_q [NUM_OUT];
  logic signed [ACC_W-1:0]  acc_q;
  logic                     neg_q;
  logic signed [DATA_W-1:0] w_q;
  logic signed [DATA_W-1:0] t_q;
  logic signed [DATA_W-1:0] u_q;
  logic                     flag_q;

  // output register
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_disp_q [NUM_OUT];
  logic                     out_sat_q;

  // shared units
  logic                     mul_en;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  prod_rnd;
  logic                     div_start;
  logic [DIV_W-1:0]         div_num;
  logic [DIV_W-1:0]         div_quo;
  div_stat_t                div_stat;

  // read ports, one address each
  logic [DIW-1:0]           didx;
  logic signed [DATA_W-1:0] pos_rd;
  logic signed [DATA_W-1:0] vh_rd;
  logic signed [DATA_W-1:0] fh_rd;
  logic signed [DATA_W-1:0] force_rd;
  logic signed [WEIGHT_W-1:0] weight;

  logic                     req_fire;
  logic                     out_free;
  logic [ORDER_W-1:0]       eff_mo;
  logic [2:0]               next_order;
  logic [DOF_W-1:0]         eff_dc;
  logic signed [ACC_W-1:0]  acc_abs;
  logic signed [ACC_W-1:0]  div_m;
  logic signed [ACC_W-1:0]  quo_ext;
  logic signed [DATA_W-1:0] disp_w [NUM_OUT];

  sat_t f_sat;
  sat_t w_sat;
  sat_t r_sat;
  sat_t v_sat;
  sat_t x_sat;

  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign didx     = dof_q[DIW-1:0];
  assign pos_rd   = pos_q[didx];
  assign vh_rd    = vh_q[j_q][didx];
  assign fh_rd    = fh_q[j_q][didx];
  assign force_rd = force_q[dof_q];
  assign weight   = (phase_q == PH_AB) ? AB_W12[order_q - 2'd1][j_q]
                                       : AM_W12[order_q - 2'd1][j_q];

  // order = min(steps + 1, max_order), zero max_order counts as one
  assign eff_mo     = (mo_q == '0) ? ORDER_W'(1) : mo_q;
  assign next_order = 3'(steps_q) + 3'd1;
  // zero dof count counts as one, clipped to the built dofs
  assign eff_dc     = (dc_q == '0) ? DOF_W'(1) : dc_q;

  // multiplier operand selection
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_KX: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, k_q};
        mul_b  = pos_rd;
      end
      ST_CV: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, c_q};
        mul_b  = vh_rd;
      end
      ST_MAC_MUL: begin
        mul_en = 1'b1;
        mul_a  = {{(DATA_W-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
        mul_b  = (phase_q == PH_AB) ? fh_rd : vh_rd;
      end
      ST_T_MUL: begin
        mul_en = 1'b1;
        mul_a  = w_q;
        mul_b  = {1'b0, ts_q};
      end
      ST_IM_MUL: begin
        mul_en = 1'b1;
        mul_a  = t_q;
        mul_b  = {1'b0, im_q};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  sdmi_mul #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .round_o(prod_rnd)
  );

  // twelfths with ties away from zero: (|s| + 6) / 4 / 3, sign restored after
  assign acc_abs   = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign div_m     = acc_abs + 64'sd6;
  assign div_num   = div_m[DIV_W+1:2];
  assign div_start = (state_q == ST_DIV_INIT);
  assign quo_ext   = ACC_W'(div_quo);

  sdmi_div3 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .quo_o  (div_quo),
    .stat_o (div_stat)
  );

  assign f_sat = sat32(acc_q - prod_rnd);
  assign w_sat = sat32(neg_q ? -quo_ext : quo_ext);
  assign r_sat = sat32(prod_rnd);
  assign v_sat = sat32(ACC_W'(vh_rd) + ACC_W'(u_q));
  assign x_sat = sat32(ACC_W'(pos_rd) + ACC_W'(t_q));

  // displayed displacements, zero for dofs that are not built
  for (genvar d = 0; d < NUM_OUT; d++) begin : g_disp
    if (d < MAX_DOF) begin : g_on
      assign disp_w[d] = pos_q[d];
    end else begin : g_off
      assign disp_w[d] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q        <= TIME_STEP_RST;
      im_q        <= INVERSE_MASS_RST;
      k_q         <= '0;
      c_q         <= '0;
      mo_q        <= MAX_ORDER_RST;
      dc_q        <= DOF_COUNT_RST;
      for (int d = 0; d < MAX_DOF; d++) begin
        pos_q[d] <= '0;
        for (int s = 0; s < HIST_SLOTS; s++) begin
          vh_q[s][d] <= '0;
          fh_q[s][d] <= '0;
        end
      end
      steps_q     <= '0;
      state_q     <= ST_IDLE;
      phase_q     <= PH_AB;
      dof_q       <= '0;
      active_q    <= DOF_W'(1);
      order_q     <= ORDER_W'(1);
      j_q         <= '0;
      for (int d = 0; d < NUM_OUT; d++) begin
        force_q[d]    <= '0;
        out_disp_q[d] <= '0;
      end
      acc_q       <= '0;
      neg_q       <= 1'b0;
      w_q         <= '0;
      t_q         <= '0;
      u_q         <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_sat_q   <= 1'b0;
    end else begin
      // register writes, unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIME_STEP:    ts_q <= cfg_wdata_i;
          REG_INVERSE_MASS: im_q <= cfg_wdata_i;
          REG_STIFFNESS:    k_q  <= cfg_wdata_i;
          REG_DAMPING:      c_q  <= cfg_wdata_i;
          REG_MAX_ORDER:    mo_q <= cfg_wdata_i[ORDER_W-1:0];
          REG_DOF_COUNT:    dc_q <= cfg_wdata_i[DOF_W-1:0];
          default: ;
        endcase
      end

      // in completion the output register is reloaded instead
      if (out_valid_q && rsp_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            force_q[0] <= req_i.force_a;
            force_q[1] <= req_i.force_b;
            force_q[2] <= req_i.force_c;
            order_q    <= (next_order > 3'(eff_mo)) ? eff_mo : next_order[ORDER_W-1:0];
            active_q   <= (eff_dc > MAX_DOF_C) ? MAX_DOF_C : eff_dc;
            dof_q      <= '0;
            j_q        <= '0;
            flag_q     <= 1'b0;
            state_q    <= ST_KX;
          end
        end
        ST_KX: begin
          state_q <= ST_CV;
        end
        ST_CV: begin
          acc_q   <= ACC_W'(force_rd) - prod_rnd;
          state_q <= ST_FSUM;
        end
        ST_FSUM: begin
          fh_q[2][didx] <= fh_q[1][didx];
          fh_q[1][didx] <= fh_q[0][didx];
          fh_q[0][didx] <= f_sat.val;
          flag_q        <= flag_q | f_sat.clip;
          acc_q         <= '0;
          j_q           <= '0;
          phase_q       <= PH_AB;
          state_q       <= ST_MAC_MUL;
        end
        ST_MAC_MUL: begin
          state_q <= ST_MAC_ACC;
        end
        ST_MAC_ACC: begin
          acc_q <= acc_q + prod;
          if (j_q == order_q - 2'd1) begin
            // slot index back to zero so v0 reads through the same port
            j_q     <= '0;
            state_q <= ST_DIV_INIT;
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= ST_MAC_MUL;
          end
        end
        ST_DIV_INIT: begin
          neg_q   <= acc_q[ACC_W-1];
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            state_q <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          w_q     <= w_sat.val;
          flag_q  <= flag_q | w_sat.clip;
          state_q <= ST_T_MUL;
        end
        ST_T_MUL: begin
          state_q <= ST_T_RND;
        end
        ST_T_RND: begin
          t_q     <= r_sat.val;
          flag_q  <= flag_q | r_sat.clip;
          state_q <= (phase_q == PH_AB) ? ST_IM_MUL : ST_X_UPD;
        end
        ST_IM_MUL: begin
          state_q <= ST_U_RND;
        end
        ST_U_RND: begin
          u_q     <= r_sat.val;
          flag_q  <= flag_q | r_sat.clip;
          state_q <= ST_V_UPD;
        end
        ST_V_UPD: begin
          // old v0 moves down a slot, new velocity lands in slot zero
          vh_q[2][didx] <= vh_q[1][didx];
          vh_q[1][didx] <= vh_q[0][didx];
          vh_q[0][didx] <= v_sat.val;
          flag_q        <= flag_q | v_sat.clip;
          acc_q         <= '0;
          j_q           <= '0;
          phase_q       <= PH_AM;
          state_q       <= ST_MAC_MUL;
        end
        ST_X_UPD: begin
          pos_q[didx] <= x_sat.val;
          flag_q      <= flag_q | x_sat.clip;
          if (dof_q == active_q - 2'd1) begin
            state_q <= ST_DONE;
          end else begin
            dof_q   <= dof_q + 2'd1;
            state_q <= ST_KX;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            for (int d = 0; d < NUM_OUT; d++) begin
              out_disp_q[d] <= disp_w[d];
            end
            out_sat_q   <= flag_q;
            out_valid_q <= 1'b1;
            if (steps_q != 2'd3) begin
              steps_q <= steps_q + 2'd1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready          = (state_q == ST_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.displacement_a = out_disp_q[0];
  assign rsp_o.displacement_b = out_disp_q[1];
  assign rsp_o.displacement_c = out_disp_q[2];
  assign rsp_o.saturated      = out_sat_q;

  // checks
  `SDMI_ASSERT_NXT(a_transfer_starts_dof, req_fire, state_q == ST_KX, "transfer did not start work")
  `SDMI_ASSERT_IMP(a_dof_in_range, state_q != ST_IDLE && state_q != ST_DONE, dof_q < active_q, "dof index beyond active count")
  `SDMI_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result appeared outside completion")
  `SDMI_ASSERT_NXT(a_steps_no_wrap, steps_q != 2'd0, steps_q != 2'd0, "step count wrapped")
  `SDMI_ASSERT_IMP(a_div_running, state_q == ST_DIV_WAIT, div_stat.busy || div_stat.done, "waiting on an idle divider")

endmodule

// ===== rtl/sdmi_mul.sv =====
// ---------------------------------------------------------------------------
// sdmi_mul
// shared registered 32x32 signed multiplier with fixed-point rounding
// ---------------------------------------------------------------------------
module sdmi_mul import sdmi_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic signed [ACC_W-1:0]  prod_o,
  output logic signed [ACC_W-1:0]  round_o
);

  localparam logic signed [ACC_W-1:0] HALF = 64'sd1 <<< (FRACTION_BITS - 1);

  logic signed [ACC_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (en_i) begin
      prod_q <= ACC_W'(a_i) * ACC_W'(b_i);
    end
  end

  // round to nearest, ties toward plus infinity
  assign prod_o  = prod_q;
  assign round_o = (prod_q + HALF) >>> FRACTION_BITS;

endmodule

// ===== rtl/sdmi_div3.sv =====
// ---------------------------------------------------------------------------
// sdmi_div3
// iterative unsigned divide by three, several quotient bits per cycle
// ---------------------------------------------------------------------------
module sdmi_div3 import sdmi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  output logic [DIV_W-1:0] quo_o,
  output div_stat_t        stat_o
);

  logic [DIV_W-1:0]     num_q;
  logic [DIV_W-1:0]     quo_q;
  logic [1:0]           rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DIV_BITS-1:0]  qbits;
  logic [1:0]           rem_n;

  // restoring steps, remainder stays below three
  always_comb begin
    logic [2:0] trial;
    logic [1:0] r;
    r     = rem_q;
    qbits = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {r, num_q[DIV_W-1-k]};
      if (trial >= DIVISOR) begin
        qbits[DIV_BITS-1-k] = 1'b1;
        r = 2'(trial - DIVISOR);
      end else begin
        r = trial[1:0];
      end
    end
    rem_n = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      num_q  <= num_i;
      quo_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= num_q << DIV_BITS;
      quo_q <= {quo_q[DIV_W-DIV_BITS-1:0], qbits};
      rem_q <= rem_n;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_CYC - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
